@@ src/tlrc_pkg.sv @@
// Package for the thick line raster canvas: sizes, field types, codes and
// the sequencer state type. Used by the interfaces, core and test bench.
package tlrc_pkg;

  // Canvas and coordinate sizes
  localparam int CANVAS_DIM = 64;
  localparam int COORD_BITS = 10;
  localparam int XY_BITS    = $clog2(CANVAS_DIM);
  localparam int DEPTH      = CANVAS_DIM * CANVAS_DIM;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int PIX_BITS   = 8;
  localparam int STEP_BITS  = 11;
  localparam int CFG_BITS   = 7;
  localparam int CFG_IDX_BITS = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   diff_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [ADDR_BITS-1:0]  addr_t;
  typedef logic        [PIX_BITS-1:0]   pix_t;
  typedef logic        [STEP_BITS-1:0]  step_t;
  typedef logic        [CFG_BITS-1:0]   cfg_t;
  typedef logic        [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic        [2:0]            brush_t;

  // Operation codes
  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam cfg_idx_t REG_ACTIVE_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_ACTIVE_HEIGHT = cfg_idx_t'(1);

  localparam cfg_t CFG_RESET = cfg_t'(64);

  // Brush slots: center, right, left, up, down
  localparam brush_t BRUSH_CENTER = brush_t'(0);
  localparam brush_t BRUSH_RIGHT  = brush_t'(1);
  localparam brush_t BRUSH_LEFT   = brush_t'(2);
  localparam brush_t BRUSH_UP     = brush_t'(3);
  localparam brush_t BRUSH_DOWN   = brush_t'(4);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_STAMP,
    S_READ,
    S_DONE
  } state_t;

endpackage

@@ src/tlrc_in_if.sv @@
// Input channel of the raster canvas: valid/ready handshake plus one item.
// Depends on tlrc_pkg for the field types.
interface tlrc_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  tlrc_pkg::coord_t  x_start;
  tlrc_pkg::coord_t  y_start;
  tlrc_pkg::coord_t  x_end;
  tlrc_pkg::coord_t  y_end;
  tlrc_pkg::pix_t    pen_value;
  logic              thick;

  modport source (
    output valid, operation, x_start, y_start, x_end, y_end, pen_value, thick,
    input  ready
  );
  modport sink (
    input  valid, operation, x_start, y_start, x_end, y_end, pen_value, thick,
    output ready
  );
endinterface

@@ src/tlrc_out_if.sv @@
// Result channel of the raster canvas: valid/ready handshake plus one result.
// Depends on tlrc_pkg for the field types.
interface tlrc_out_if;
  logic            valid;
  logic            ready;
  tlrc_pkg::pix_t  read_value;
  tlrc_pkg::step_t step_count;

  modport source (output valid, read_value, step_count, input ready);
  modport sink   (input valid, read_value, step_count, output ready);
endinterface

@@ src/tlrc_canvas_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Stand-alone, no package dependency.
module tlrc_canvas_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/thick_line_raster_canvas_core.sv @@
// Top level of the thick line raster canvas: sequencer, line walker and
// the canvas memory. Depends on tlrc_pkg, tlrc_in_if, tlrc_out_if, tlrc_canvas_ram.

// After reset the block sweeps the 64x64 byte canvas to zero, one cell a
// cycle, and accepts no item until the sweep is over (configuration writes
// are taken at any time). Items are handled one at a time. A read's data
// is registered in the RAM and moves on to the output register once that is
// free. A draw of N = max(|dx|,|dy|) steps stamps the brush once per step:
// the canvas memory has a single write port, and the brush writes one cell
// per cycle. A finished result waits in an output register, so the next
// item can be accepted while the previous result is still waiting.
module thick_line_raster_canvas_core (
  input  logic                clk,
  input  logic                rst_n,
  tlrc_in_if.sink             in_ch,
  tlrc_out_if.source          out_ch,
  input  logic                cfg_wr_en,
  input  tlrc_pkg::cfg_idx_t  cfg_index,
  input  tlrc_pkg::cfg_t      cfg_wdata
);
  import tlrc_pkg::*;

  // Point inside the active area
  function automatic logic in_area(input diff_t x, input diff_t y,
                                   input cfg_t lw, input cfg_t lh);
    in_area = !x[COORD_BITS] && !y[COORD_BITS] &&
              (mag_t'(x) < mag_t'(lw)) && (mag_t'(y) < mag_t'(lh));
  endfunction

  // Cell (x, y) lives at x*CANVAS_DIM + y
  function automatic addr_t cell_addr(input diff_t x, input diff_t y);
    cell_addr = addr_t'(addr_t'(x[XY_BITS-1:0]) * addr_t'(CANVAS_DIM)) +
                addr_t'(y[XY_BITS-1:0]);
  endfunction

  state_t state_r, state_nxt;
  addr_t  clr_addr_r, clr_addr_nxt;
  coord_t cx_r, cx_nxt, cy_r, cy_nxt, xe_r, xe_nxt, ye_r, ye_nxt;
  pix_t   pen_r, pen_nxt;
  logic   thick_r, thick_nxt;
  step_t  steps_r, steps_nxt;
  brush_t brush_r, brush_nxt;
  logic   read_in_r, read_in_nxt;
  logic   out_valid_r, out_valid_nxt;
  pix_t   out_read_r, out_read_nxt;
  step_t  out_steps_r, out_steps_nxt;
  cfg_t   width_r, width_nxt, height_r, height_nxt;

  cfg_t   lim_w, lim_h;
  diff_t  dx, dy, px, py;
  mag_t   ax, ay;
  logic   at_end, step_x, step_y;
  coord_t mv_x, mv_y;
  logic   pt_inside, finish_ok, load_out, in_acc;

  logic   wr_en, rd_en;
  addr_t  wr_addr, rd_addr;
  pix_t   wr_data, rd_data;

  tlrc_canvas_ram #(
    .DEPTH (DEPTH),
    .WIDTH (PIX_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Clamp active area to the canvas
  always_comb begin
    lim_w = (int'(width_r)  > CANVAS_DIM) ? cfg_t'(CANVAS_DIM) : width_r;
    lim_h = (int'(height_r) > CANVAS_DIM) ? cfg_t'(CANVAS_DIM) : height_r;
  end

  // Walker: choose the next move from the remaining distance
  always_comb begin
    dx     = diff_t'(xe_r) - diff_t'(cx_r);
    dy     = diff_t'(ye_r) - diff_t'(cy_r);
    ax     = dx[COORD_BITS] ? mag_t'(-dx) : mag_t'(dx);
    ay     = dy[COORD_BITS] ? mag_t'(-dy) : mag_t'(dy);
    at_end = (ax == '0) && (ay == '0);
    step_x = (ax >= ay) && (ax != '0);
    step_y = (ay >= ax) && (ay != '0);
    mv_x   = cx_r;
    mv_y   = cy_r;
    if (step_x) begin
      mv_x = dx[COORD_BITS] ? cx_r - coord_t'(1) : cx_r + coord_t'(1);
    end
    if (step_y) begin
      mv_y = dy[COORD_BITS] ? cy_r - coord_t'(1) : cy_r + coord_t'(1);
    end
  end

  // Brush point for the current slot
  always_comb begin
    px = diff_t'(cx_r);
    py = diff_t'(cy_r);
    case (brush_r)
      BRUSH_RIGHT: px = diff_t'(cx_r) + diff_t'(1);
      BRUSH_LEFT:  px = diff_t'(cx_r) - diff_t'(1);
      BRUSH_UP:    py = diff_t'(cy_r) + diff_t'(1);
      BRUSH_DOWN:  py = diff_t'(cy_r) - diff_t'(1);
      default: ;
    endcase
    pt_inside = in_area(px, py, lim_w, lim_h);
  end

  assign finish_ok = !out_valid_r || out_ch.ready;
  assign in_acc    = in_ch.valid && in_ch.ready;

  // Sequencer: next state, memory ports and result load
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    pen_nxt       = pen_r;
    thick_nxt     = thick_r;
    steps_nxt     = steps_r;
    brush_nxt     = brush_r;
    read_in_nxt   = read_in_r;
    out_read_nxt  = out_read_r;
    out_steps_nxt = out_steps_r;
    load_out      = 1'b0;
    in_ch.ready   = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cell_addr(px, py);
    wr_data       = pen_r;
    rd_en         = 1'b0;
    rd_addr       = cell_addr(diff_t'(in_ch.x_start), diff_t'(in_ch.y_start));

    unique case (state_r)
      S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = '0;
        clr_addr_nxt = clr_addr_r + addr_t'(1);
        if (clr_addr_r == addr_t'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cx_nxt    = in_ch.x_start;
          cy_nxt    = in_ch.y_start;
          xe_nxt    = in_ch.x_end;
          ye_nxt    = in_ch.y_end;
          pen_nxt   = in_ch.pen_value;
          thick_nxt = in_ch.thick;
          steps_nxt = '0;
          if (in_ch.operation == OP_READ) begin
            rd_en       = 1'b1;
            read_in_nxt = in_area(diff_t'(in_ch.x_start), diff_t'(in_ch.y_start),
                                  lim_w, lim_h);
            state_nxt   = S_READ;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (at_end) begin
          state_nxt = S_DONE;
        end else begin
          cx_nxt    = mv_x;
          cy_nxt    = mv_y;
          steps_nxt = steps_r + step_t'(1);
          brush_nxt = BRUSH_CENTER;
          state_nxt = S_STAMP;
        end
      end
      S_STAMP: begin
        wr_en = pt_inside;
        if (thick_r && (brush_r != BRUSH_DOWN)) begin
          brush_nxt = brush_r + brush_t'(1);
        end else if (at_end) begin
          state_nxt = S_DONE;
        end else begin
          // Last brush slot: take the next move in the same cycle
          cx_nxt    = mv_x;
          cy_nxt    = mv_y;
          steps_nxt = steps_r + step_t'(1);
          brush_nxt = BRUSH_CENTER;
        end
      end
      S_READ: begin
        if (finish_ok) begin
          load_out      = 1'b1;
          out_read_nxt  = read_in_r ? rd_data : '0;
          out_steps_nxt = '0;
          state_nxt     = S_IDLE;
        end
      end
      S_DONE: begin
        if (finish_ok) begin
          load_out      = 1'b1;
          out_read_nxt  = '0;
          out_steps_nxt = steps_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);
  end

  // Configuration register write decode
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH:  width_nxt  = cfg_wdata;
        REG_ACTIVE_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      width_r     <= CFG_RESET;
      height_r    <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    xe_r        <= xe_nxt;
    ye_r        <= ye_nxt;
    pen_r       <= pen_nxt;
    thick_r     <= thick_nxt;
    steps_r     <= steps_nxt;
    brush_r     <= brush_nxt;
    read_in_r   <= read_in_nxt;
    out_read_r  <= out_read_nxt;
    out_steps_r <= out_steps_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_read_r;
  assign out_ch.step_count = out_steps_r;

`ifndef ASSERT_OFF
  // No result while the canvas is still being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !load_out)
    else $error("result produced during clear sweep");

  // An accepted draw starts the walk
  a_draw_walks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.operation == OP_DRAW)) |=> (state_r == S_WALK))
    else $error("draw did not start walking");

  // A thin brush never leaves the center slot
  a_thin_center: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_STAMP) && !thick_r) |-> (brush_r == BRUSH_CENTER))
    else $error("thin draw used a neighbor slot");

  // A finished draw stands on its end point
  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && (cx_r != xe_r || cy_r != ye_r)) |-> 1'b0)
    else $error("draw finished away from its end point");
`endif

endmodule

@@ test/thick_line_raster_canvas_core_test.sv @@
// Self-checking bench for thick_line_raster_canvas_core. It walks a table of
// directed draws and reads, then random strokes, and checks them against a local canvas.
// Depends on tlrc_pkg, tlrc_in_if, tlrc_out_if and the core RTL.
module thick_line_raster_canvas_core_test;
  import tlrc_pkg::*;

  localparam int QUIET_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 138;
  localparam int NUM_PROBES   = 25;

  // Register indexes that the core has no register for
  localparam cfg_idx_t REG_SPARE_2 = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_3 = cfg_idx_t'(3);

  // Whether a table row carries its own expected result
  localparam logic FIXED     = 1'b1;
  localparam logic PREDICTED = 1'b0;

  localparam coord_t C_MIN = coord_t'(-512);
  localparam coord_t C_MAX = coord_t'(511);

  typedef struct packed {
    logic   operation;
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
    pix_t   pen_value;
    logic   thick;
  } stroke_t;

  typedef struct packed {
    pix_t  read_value;
    step_t step_count;
  } cell_result_t;

  typedef struct packed {
    stroke_t      stroke;
    logic         fixed;
    cell_result_t want;
  } probe_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    // canvas reads back zero after the clearing sweep
    '{'{OP_READ, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'h00, 11'd0}},
    '{'{OP_READ, 10'sd63, 10'sd63, C_MAX, C_MIN, 8'hFF, 1'b1}, FIXED, '{8'h00, 11'd0}},
    // equal endpoints: no step, nothing painted
    '{'{OP_DRAW, 10'sd7, 10'sd7, 10'sd7, 10'sd7, 8'hFF, 1'b1}, FIXED, '{8'h00, 11'd0}},
    '{'{OP_READ, 10'sd7, 10'sd7, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'h00, 11'd0}},
    // corner to corner over the whole coordinate range
    '{'{OP_DRAW, C_MIN, C_MIN, C_MAX, C_MAX, 8'hA5, 1'b0}, FIXED, '{8'h00, 11'd1023}},
    '{'{OP_READ, 10'sd10, 10'sd10, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'hA5, 11'd0}},
    '{'{OP_DRAW, C_MAX, C_MIN, C_MIN, C_MAX, 8'h5A, 1'b1}, FIXED, '{8'h00, 11'd1023}},
    '{'{OP_READ, 10'sd0, 10'sd0, 10'sd0, 10'sd0, 8'h00, 1'b0}, PREDICTED, '{8'h00, 11'd0}},
    // short strokes inside the area and across its edges
    '{'{OP_DRAW, 10'sd5, 10'sd5, 10'sd20, 10'sd9, 8'h01, 1'b0}, PREDICTED, '{8'h00, 11'd0}},
    '{'{OP_DRAW, 10'sd30, 10'sd2, 10'sd30, 10'sd40, 8'h80, 1'b1}, PREDICTED, '{8'h00, 11'd0}},
    '{'{OP_DRAW, 10'sd63, 10'sd0, 10'sd0, 10'sd63, 8'hC3, 1'b1}, PREDICTED, '{8'h00, 11'd0}},
    '{'{OP_DRAW, -10'sd3, 10'sd10, 10'sd70, 10'sd10, 8'h33, 1'b1}, PREDICTED, '{8'h00, 11'd0}},
    // one unit left: jump to the end; equal distances: one diagonal move
    '{'{OP_DRAW, 10'sd1, 10'sd1, 10'sd2, 10'sd1, 8'h11, 1'b0}, FIXED, '{8'h00, 11'd1}},
    '{'{OP_DRAW, 10'sd1, 10'sd1, 10'sd2, 10'sd2, 8'h22, 1'b0}, FIXED, '{8'h00, 11'd1}},
    // reads outside the area return zero
    '{'{OP_READ, 10'sd64, 10'sd0, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'h00, 11'd0}},
    '{'{OP_READ, -10'sd1, 10'sd5, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'h00, 11'd0}},
    '{'{OP_READ, C_MAX, C_MAX, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'h00, 11'd0}},
    '{'{OP_READ, C_MIN, C_MIN, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'h00, 11'd0}},
    '{'{OP_READ, 10'sd0, 10'sd64, 10'sd0, 10'sd0, 8'h00, 1'b0}, FIXED, '{8'h00, 11'd0}},
    // reads of painted cells
    '{'{OP_READ, 10'sd12, 10'sd7, 10'sd0, 10'sd0, 8'h00, 1'b0}, PREDICTED, '{8'h00, 11'd0}},
    '{'{OP_READ, 10'sd30, 10'sd20, 10'sd0, 10'sd0, 8'h00, 1'b0}, PREDICTED, '{8'h00, 11'd0}},
    '{'{OP_READ, 10'sd31, 10'sd20, 10'sd0, 10'sd0, 8'h00, 1'b0}, PREDICTED, '{8'h00, 11'd0}},
    '{'{OP_READ, 10'sd63, 10'sd0, 10'sd0, 10'sd0, 8'h00, 1'b0}, PREDICTED, '{8'h00, 11'd0}},
    '{'{OP_READ, 10'sd2, 10'sd2, 10'sd0, 10'sd0, 8'h00, 1'b0}, PREDICTED, '{8'h00, 11'd0}},
    // zero pen over the main diagonal
    '{'{OP_DRAW, 10'sd0, 10'sd0, 10'sd63, 10'sd63, 8'h00, 1'b1}, PREDICTED, '{8'h00, 11'd0}}
  };

  // Active area for each random phase; the last phase draws its own
  localparam cfg_t AREA_W [PHASES] = '{7'd1, 7'd127, 7'd0, 7'd64, 7'd23, 7'd64, 7'd100, 7'd0};
  localparam cfg_t AREA_H [PHASES] = '{7'd1, 7'd127, 7'd64, 7'd1, 7'd50, 7'd0, 7'd9, 7'd0};

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_wr_en;
  cfg_idx_t cfg_index;
  cfg_t     cfg_wdata;

  tlrc_in_if  in_ch ();
  tlrc_out_if out_ch ();

  thick_line_raster_canvas_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the canvas and the area registers
  pix_t canvas_image [DEPTH] = '{default: '0};
  cfg_t width_reg  = CFG_RESET;
  cfg_t height_reg = CFG_RESET;

  cell_result_t pending_results [$];
  cell_result_t oldest_result;
  int           mismatches     = 0;
  int           send_gap_pct   = 36;
  int           recv_stall_pct = 78;
  int unsigned  quiet_cycles   = 0;

  function automatic int area_cols();
    return (width_reg > CANVAS_DIM) ? CANVAS_DIM : int'(width_reg);
  endfunction

  function automatic int area_rows();
    return (height_reg > CANVAS_DIM) ? CANVAS_DIM : int'(height_reg);
  endfunction

  function automatic bit in_area(input int x, input int y);
    return x >= 0 && y >= 0 && x < area_cols() && y < area_rows();
  endfunction

  function automatic void paint_cell(input int x, input int y, input pix_t pen);
    if (in_area(x, y)) begin
      canvas_image[x * CANVAS_DIM + y] = pen;
    end
  endfunction

  // Walk or read one transaction on the local canvas and return its result
  function automatic cell_result_t predict_stroke(input stroke_t s);
    cell_result_t r;
    int cx, cy, ex, ey, dx, dy, ax, ay, steps;
    r = '0;
    steps = 0;
    if (s.operation == OP_READ) begin
      cx = s.x_start;
      cy = s.y_start;
      if (in_area(cx, cy)) begin
        r.read_value = canvas_image[cx * CANVAS_DIM + cy];
      end
    end else begin
      cx = s.x_start;
      cy = s.y_start;
      ex = s.x_end;
      ey = s.y_end;
      while (cx != ex || cy != ey) begin
        dx = ex - cx;
        dy = ey - cy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax + ay > 1) begin
          if (ax >= ay) cx += (dx > 0) ? 1 : -1;
          if (ay >= ax) cy += (dy > 0) ? 1 : -1;
        end else begin
          cx = ex;
          cy = ey;
        end
        steps++;
        paint_cell(cx, cy, s.pen_value);
        if (s.thick) begin
          paint_cell(cx + 1, cy, s.pen_value);
          paint_cell(cx - 1, cy, s.pen_value);
          paint_cell(cx, cy + 1, s.pen_value);
          paint_cell(cx, cy - 1, s.pen_value);
        end
      end
    end
    r.step_count = step_t'(steps);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_stroke(input stroke_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= s.operation;
    in_ch.x_start   <= s.x_start;
    in_ch.y_start   <= s.y_start;
    in_ch.x_end     <= s.x_end;
    in_ch.y_end     <= s.y_end;
    in_ch.pen_value <= s.pen_value;
    in_ch.thick     <= s.thick;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write one register; the caller drops the enable after the last write
  task automatic write_reg(input cfg_idx_t idx, input cfg_t value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_ACTIVE_WIDTH) begin
      width_reg = value;
    end else if (idx == REG_ACTIVE_HEIGHT) begin
      height_reg = value;
    end
    @(posedge clk);
  endtask

  // Stall the result side at random and check each result transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: read_value %0h step_count %0d",
                                    out_ch.read_value, out_ch.step_count));
        end else begin
          oldest_result = pending_results.pop_front();
          if (out_ch.read_value !== oldest_result.read_value) begin
            report_mismatch($sformatf("read_value %0h, expected %0h",
                                      out_ch.read_value, oldest_result.read_value));
          end
          if (out_ch.step_count !== oldest_result.step_count) begin
            report_mismatch($sformatf("step_count %0d, expected %0d",
                                      out_ch.step_count, oldest_result.step_count));
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    stroke_t      s;
    cell_result_t model_out;
    cfg_t         next_w, next_h;
    int           lw, lh, kind;

    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_index       <= REG_ACTIVE_WIDTH;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_DRAW;
    in_ch.x_start   <= '0;
    in_ch.y_start   <= '0;
    in_ch.x_end     <= '0;
    in_ch.y_end     <= '0;
    in_ch.pen_value <= '0;
    in_ch.thick     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table at the reset area; the core clears its canvas first
    for (int i = 0; i < NUM_PROBES; i++) begin
      send_stroke(PROBES[i].stroke);
      model_out = predict_stroke(PROBES[i].stroke);
      pending_results.push_back(PROBES[i].fixed ? PROBES[i].want : model_out);
    end

    for (int p = 0; p < PHASES; p++) begin
      // Hold off until the core is idle, then move the active area
      in_ch.valid <= 1'b0;
      wait_drained();
      next_w = (p == PHASES - 1) ? cfg_t'($urandom) : AREA_W[p];
      next_h = (p == PHASES - 1) ? cfg_t'($urandom) : AREA_H[p];
      write_reg(REG_SPARE_2, cfg_t'($urandom));
      write_reg(REG_ACTIVE_WIDTH, next_w);
      write_reg(REG_SPARE_3, cfg_t'($urandom));
      write_reg(REG_ACTIVE_HEIGHT, next_h);
      cfg_wr_en <= 1'b0;

      if (p < 3) begin
        send_gap_pct   = 36;
        recv_stall_pct = 78;
      end else if (p < 6) begin
        send_gap_pct   = 78;
        recv_stall_pct = 36;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      lw = area_cols();
      lh = area_rows();

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        s.pen_value = pix_t'($urandom);
        s.thick     = 1'($urandom_range(1));
        s.x_end     = coord_t'($urandom);
        s.y_end     = coord_t'($urandom);
        kind = $urandom_range(99);
        if (kind < 40) begin
          // reads mostly aim at the active area and just past it
          s.operation = OP_READ;
          if (kind < 34) begin
            s.x_start = coord_t'(int'($urandom_range(lw + 1)) - 1);
            s.y_start = coord_t'(int'($urandom_range(lh + 1)) - 1);
          end else begin
            s.x_start = coord_t'($urandom);
            s.y_start = coord_t'($urandom);
          end
        end else begin
          // draws are mostly short strokes near the canvas
          s.operation = OP_DRAW;
          s.x_start = coord_t'(int'($urandom_range(71)) - 4);
          s.y_start = coord_t'(int'($urandom_range(71)) - 4);
          if (kind < 44) begin
            s.x_start = coord_t'($urandom);
            s.y_start = coord_t'($urandom);
          end else if (kind < 48) begin
            s.x_end = s.x_start;
            s.y_end = s.y_start;
          end else if (kind < 58) begin
            s.x_end = coord_t'(int'($urandom_range(79)) - 8);
            s.y_end = coord_t'(int'($urandom_range(79)) - 8);
          end else begin
            s.x_end = coord_t'(int'(s.x_start) + int'($urandom_range(48)) - 24);
            s.y_end = coord_t'(int'(s.y_start) + int'($urandom_range(48)) - 24);
          end
        end
        send_stroke(s);
        model_out = predict_stroke(s);
        pending_results.push_back(model_out);
      end
    end

    // Drain, then watch a while for stray results
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
